/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/core/cfr_pkg.sv */
// Package: constants, types and helper functions of the filter bank.
`default_nettype none
package cfr_pkg;
    localparam int MAX_CHANNELS   = 64;
    localparam int MAX_BAND_ORDER = 6;
    localparam int SLOTS          = 18;
    localparam int CH_W           = $clog2(MAX_CHANNELS);
    localparam int NCH_W          = CH_W + 1;
    localparam int COEF_DEPTH     = MAX_CHANNELS * SLOTS;
    localparam int CADDR_W        = $clog2(COEF_DEPTH);
    localparam int DLY_W          = 48;
    localparam int BAND_ROW_W     = MAX_BAND_ORDER * DLY_W;
    localparam int LP_ROW_W       = 2 * DLY_W;
    localparam int PROD_W         = 54;
    localparam int ACC_W          = 56;

    // item kinds
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_PROCESS = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // register indexes
    localparam logic CFG_ORDER    = 1'b0;
    localparam logic CFG_CHANNELS = 1'b1;

    // coefficient slots
    localparam logic [4:0] SLOT_BAND_A_OFS = 5'd6;
    localparam logic [4:0] SLOT_LP_B       = 5'd13;
    localparam logic [4:0] SLOT_LP_A_OFS   = 5'd15;
    localparam logic [4:0] SLOT_COUNT      = 5'd18;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_LOAD,
        ST_STEP,
        ST_FETCH,
        ST_START,
        ST_WAIT,
        ST_STORE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  en;
        logic [CH_W-1:0]       addr;
        logic [BAND_ROW_W-1:0] band;
        logic [LP_ROW_W-1:0]   lp;
    } dly_wr_t;

    function automatic logic [CADDR_W-1:0] coef_addr(input logic [CH_W-1:0] ch,
                                                      input logic [4:0] slot);
        logic [CADDR_W-1:0] c;
        c = {{(CADDR_W-CH_W){1'b0}}, ch};
        return (c << 4) + (c << 1) + {{(CADDR_W-5){1'b0}}, slot};
    endfunction

    function automatic logic [DLY_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = 56'sh00_7FFF_FFFF_FFFF;
        lo = 56'shFF_8000_0000_0000;
        if (v > hi)
            return 48'h7FFF_FFFF_FFFF;
        else if (v < lo)
            return 48'h8000_0000_0000;
        else
            return v[DLY_W-1:0];
    endfunction

    // Q8.40 to Q4.20 with round half up and clamp
    function automatic logic [23:0] to_out(input logic [DLY_W-1:0] y);
        logic signed [28:0] o;
        o = $signed({y[47], y[47:20]}) + $signed({28'd0, y[19]});
        if (o > 29'sd8388607)
            return 24'h7FFFFF;
        else if (o < -29'sd8388608)
            return 24'h800000;
        else
            return o[23:0];
    endfunction
endpackage
`default_nettype wire

/* rtl/core/cfr_mul.sv */
// Digit-serial multiplier: 32-bit coefficient times 48-bit value, byte per cycle.
`default_nettype none
module cfr_mul (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [31:0]                  coef,
    input  wire logic [cfr_pkg::DLY_W-1:0]    value,
    output logic                              done,
    output logic [cfr_pkg::PROD_W-1:0]        product
);
    logic signed [31:0]              c_reg;
    logic [cfr_pkg::DLY_W-1:0]       v_reg;
    logic signed [41:0]              h_reg;
    logic [cfr_pkg::DLY_W-1:0]       lo_reg;
    logic [2:0]                      cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [cfr_pkg::PROD_W-1:0]      prod_reg;

    logic signed [8:0]  digit;
    logic signed [40:0] part;
    logic signed [41:0] sum;
    logic [79:0]        full;

    // top byte of the value is signed, the rest unsigned
    assign digit = (cnt_reg == 3'd5) ? {v_reg[7], v_reg[7:0]} : {1'b0, v_reg[7:0]};
    assign part  = c_reg * digit;
    assign sum   = h_reg + {part[40], part};
    assign full  = {h_reg[31:0], lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= 3'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != 3'd6)
                    cnt_reg <= cnt_reg + 3'd1;
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            c_reg <= coef;
            v_reg <= value;
            h_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd6)
            begin
                v_reg  <= v_reg >> 8;
                lo_reg <= {sum[7:0], lo_reg[47:8]};
                h_reg  <= sum >>> 8;
            end
            else
                // floor((p + 2^25) / 2^26)
                prod_reg <= full[79:26] + {53'd0, full[25]};
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;
endmodule
`default_nettype wire

/* rtl/core/cfr_coef_mem.sv */
// Coefficient memory: one write port, one registered read port.
`default_nettype none
module cfr_coef_mem (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [cfr_pkg::CADDR_W-1:0]   waddr,
    input  wire logic [31:0]                   wdata,
    input  wire logic [cfr_pkg::CADDR_W-1:0]   raddr,
    output logic [31:0]                        rdata
);
    logic [31:0] mem [cfr_pkg::COEF_DEPTH];
    logic [31:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;
endmodule
`default_nettype wire

/* rtl/core/cfr_dly_mem.sv */
// Delay-state rows, one per channel, with row valid bits for fast clearing.
`default_nettype none
module cfr_dly_mem (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            clear,
    input  wire cfr_pkg::dly_wr_t                wr,
    input  wire logic [cfr_pkg::CH_W-1:0]        raddr,
    output logic [cfr_pkg::BAND_ROW_W-1:0]       band,
    output logic [cfr_pkg::LP_ROW_W-1:0]         lp
);
    logic [cfr_pkg::BAND_ROW_W-1:0] band_mem [cfr_pkg::MAX_CHANNELS];
    logic [cfr_pkg::LP_ROW_W-1:0]   lp_mem   [cfr_pkg::MAX_CHANNELS];
    logic [cfr_pkg::MAX_CHANNELS-1:0] valid_reg;
    logic [cfr_pkg::BAND_ROW_W-1:0] band_rd_reg;
    logic [cfr_pkg::LP_ROW_W-1:0]   lp_rd_reg;
    logic                           vld_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (clear)
            valid_reg <= '0;
        else if (wr.en)
            valid_reg[wr.addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            band_mem[wr.addr] <= wr.band;
            lp_mem[wr.addr]   <= wr.lp;
        end
        band_rd_reg <= band_mem[raddr];
        lp_rd_reg   <= lp_mem[raddr];
        vld_rd_reg  <= valid_reg[raddr];
    end

    // a row never written since reset or clear reads as zero
    assign band = vld_rd_reg ? band_rd_reg : '0;
    assign lp   = vld_rd_reg ? lp_rd_reg : '0;
endmodule
`default_nettype wire

/* rtl/core/cochlear_filterbank_rectifier.sv */
// Top level: band-pass filter bank with half-wave rectifier and low-pass smoothing.
//
// channel  | handshake         | payload
// ---------+-------------------+--------------------------------------------
// s_       | tvalid / tready   | tuser: operation; tdata: chan, coef idx, coef, sample
// m_       | tvalid / tready   | tdata: channel, band, rectified; tlast: last channel
// cfg_     | cfg_we only       | cfg_addr register index, cfg_wdata value
//
// After reset the coefficient memory is zeroed, one word a cycle, with s_tready
// low. Write and clear items leave the sequencer idle. A sample item is processed
// channel by channel: each of the 2*order+6 products per channel runs through
// one shared byte-serial multiplier after its coefficient fetch. A stalled m_
// side holds the sequencer at the result stage; a new item is taken only once
// the last result is registered.
`default_nettype none
`include "assert_macros.svh"
module cochlear_filterbank_rectifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // channel_index[5:0], coef_index[10:6],
                                        // coef_value[42:11], sample_in[58:43]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    // master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // channel_out[5:0], band_out[29:6],
                                        // rectified_out[53:30]
    output logic             m_tlast,   // last_channel
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [6:0]  cfg_wdata
);
    localparam int DW = cfr_pkg::DLY_W;

    cfr_pkg::state_t state_reg, state_next;

    logic [cfr_pkg::CADDR_W-1:0] clr_cnt_reg;
    logic [1:0]                  order_sel_reg;
    logic [6:0]                  chans_reg;
    logic [2:0]                  n_reg;
    logic [cfr_pkg::NCH_W-1:0]   nch_reg;
    logic [cfr_pkg::CH_W-1:0]    ch_reg;
    logic                        sec_reg;     // 0 band-pass, 1 low-pass
    logic [2:0]                  k_reg;       // step within section
    logic                        ph_reg;      // 0 feed-forward, 1 feedback
    logic [15:0]                 sample_reg;
    logic signed [cfr_pkg::ACC_W-1:0] acc_reg;
    logic [DW-1:0]               bz_reg [cfr_pkg::MAX_BAND_ORDER];
    logic [DW-1:0]               lz_reg [2];
    logic [DW-1:0]               yb_reg;
    logic [DW-1:0]               yl_reg;

    logic                        m_tvalid_reg;
    logic [cfr_pkg::CH_W-1:0]    och_reg;
    logic [23:0]                 oband_reg;
    logic [23:0]                 orect_reg;
    logic                        olast_reg;

    // input fields
    logic [1:0]                  in_op;
    logic [cfr_pkg::CH_W-1:0]    in_ch;
    logic [4:0]                  in_ci;
    logic [31:0]                 in_coef;
    logic [15:0]                 in_sample;
    assign in_op     = s_tuser;
    assign in_ch     = s_tdata[5:0];
    assign in_ci     = s_tdata[10:6];
    assign in_coef   = s_tdata[42:11];
    assign in_sample = s_tdata[58:43];

    logic accept;
    assign s_tready = (state_reg == cfr_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // order and channel count as latched for a sample item
    logic [1:0]                sel_eff;
    logic [cfr_pkg::NCH_W-1:0] nch_eff;
    assign sel_eff = (order_sel_reg == 2'd0) ? 2'd1 : order_sel_reg;
    assign nch_eff = (chans_reg > 7'(cfr_pkg::MAX_CHANNELS))
                     ? cfr_pkg::NCH_W'(cfr_pkg::MAX_CHANNELS) : chans_reg;

    logic [2:0] n_cur;
    logic       last_ch;
    logic       out_free;
    logic [cfr_pkg::NCH_W-1:0] ch_ext;
    assign n_cur    = sec_reg ? 3'd2 : n_reg;
    assign ch_ext   = {1'b0, ch_reg};
    assign last_ch  = (ch_ext + 7'd1) == nch_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // coefficient memory
    logic                        cm_we;
    logic [cfr_pkg::CADDR_W-1:0] cm_waddr;
    logic [31:0]                 cm_wdata;
    logic [4:0]                  slot;
    logic [31:0]                 coef_rd;
    logic                        clearing;

    assign clearing = (state_reg == cfr_pkg::ST_CLEAR);
    assign cm_we    = clearing ||
                      (accept && in_op == cfr_pkg::OP_WRITE && in_ci < cfr_pkg::SLOT_COUNT);
    assign cm_waddr = clearing ? clr_cnt_reg : cfr_pkg::coef_addr(in_ch, in_ci);
    assign cm_wdata = clearing ? 32'd0 : in_coef;

    always_comb
    begin
        if (!sec_reg)
            slot = ph_reg ? (cfr_pkg::SLOT_BAND_A_OFS + {2'b0, k_reg}) : {2'b0, k_reg};
        else
            slot = ph_reg ? (cfr_pkg::SLOT_LP_A_OFS + {2'b0, k_reg})
                          : (cfr_pkg::SLOT_LP_B + {2'b0, k_reg});
    end

    cfr_coef_mem u_coef (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .raddr (cfr_pkg::coef_addr(ch_reg, slot)),
        .rdata (coef_rd)
    );

    // delay rows
    cfr_pkg::dly_wr_t             dly_wr;
    logic [cfr_pkg::BAND_ROW_W-1:0] band_row;
    logic [cfr_pkg::LP_ROW_W-1:0]   lp_row;
    logic [cfr_pkg::BAND_ROW_W-1:0] band_pack;

    always_comb
    begin
        for (int i = 0; i < cfr_pkg::MAX_BAND_ORDER; i++)
            band_pack[i*DW +: DW] = bz_reg[i];
    end

    assign dly_wr.en   = (state_reg == cfr_pkg::ST_EMIT) && out_free;
    assign dly_wr.addr = ch_reg;
    assign dly_wr.band = band_pack;
    assign dly_wr.lp   = {lz_reg[1], lz_reg[0]};

    cfr_dly_mem u_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (accept && in_op == cfr_pkg::OP_CLEAR),
        .wr    (dly_wr),
        .raddr (ch_reg),
        .band  (band_row),
        .lp    (lp_row)
    );

    // multiplier operand and accumulator start value
    logic [DW-1:0] xs;
    logic [DW-1:0] rect;
    logic [DW-1:0] operand;
    logic [DW-1:0] z_sel;
    logic [DW-1:0] z_init;
    assign xs   = {{7{sample_reg[15]}}, sample_reg, 25'd0};
    assign rect = yb_reg[DW-1] ? '0 : yb_reg;   // half-wave rectifier

    always_comb
    begin
        if (ph_reg)
            operand = sec_reg ? yl_reg : yb_reg;
        else
            operand = sec_reg ? rect : xs;
        if (sec_reg)
            z_sel = lz_reg[k_reg[0]];
        else if (k_reg < 3'(cfr_pkg::MAX_BAND_ORDER))
            z_sel = bz_reg[k_reg];
        else
            z_sel = '0;
        z_init = (k_reg < n_cur) ? z_sel : '0;
    end

    logic                         mul_done;
    logic [cfr_pkg::PROD_W-1:0]   mul_res;
    logic signed [cfr_pkg::ACC_W-1:0] res_ext;
    logic [DW-1:0]                acc_sat;

    cfr_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == cfr_pkg::ST_START),
        .coef    (coef_rd),
        .value   (operand),
        .done    (mul_done),
        .product (mul_res)
    );

    assign res_ext = {{2{mul_res[cfr_pkg::PROD_W-1]}}, mul_res};
    assign acc_sat = cfr_pkg::sat48(acc_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfr_pkg::ST_CLEAR:
                if (clr_cnt_reg == cfr_pkg::CADDR_W'(cfr_pkg::COEF_DEPTH - 1))
                    state_next = cfr_pkg::ST_IDLE;
            cfr_pkg::ST_IDLE:
                if (accept && in_op == cfr_pkg::OP_PROCESS && nch_eff != '0)
                    state_next = cfr_pkg::ST_ROW;
            cfr_pkg::ST_ROW:   state_next = cfr_pkg::ST_LOAD;
            cfr_pkg::ST_LOAD:  state_next = cfr_pkg::ST_STEP;
            cfr_pkg::ST_STEP:  state_next = cfr_pkg::ST_FETCH;
            cfr_pkg::ST_FETCH: state_next = cfr_pkg::ST_START;
            cfr_pkg::ST_START: state_next = cfr_pkg::ST_WAIT;
            cfr_pkg::ST_WAIT:
                if (mul_done)
                    state_next = (!ph_reg && k_reg != 3'd0) ? cfr_pkg::ST_FETCH
                                                            : cfr_pkg::ST_STORE;
            cfr_pkg::ST_STORE:
                if (k_reg < n_cur || !sec_reg)
                    state_next = cfr_pkg::ST_STEP;
                else
                    state_next = cfr_pkg::ST_EMIT;
            cfr_pkg::ST_EMIT:
                if (out_free)
                    state_next = last_ch ? cfr_pkg::ST_IDLE : cfr_pkg::ST_ROW;
            default: state_next = cfr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfr_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            order_sel_reg <= 2'd1;
            chans_reg     <= 7'd32;
            n_reg         <= 3'd2;
            nch_reg       <= '0;
            ch_reg        <= '0;
            sec_reg       <= 1'b0;
            k_reg         <= 3'd0;
            ph_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + cfr_pkg::CADDR_W'(1);
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    cfr_pkg::CFG_ORDER:    order_sel_reg <= cfg_wdata[1:0];
                    cfr_pkg::CFG_CHANNELS: chans_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept && in_op == cfr_pkg::OP_PROCESS)
            begin
                n_reg   <= {sel_eff, 1'b0};
                nch_reg <= nch_eff;
                ch_reg  <= '0;
            end
            case (state_reg)
                cfr_pkg::ST_LOAD:
                begin
                    sec_reg <= 1'b0;
                    k_reg   <= 3'd0;
                    ph_reg  <= 1'b0;
                end
                cfr_pkg::ST_WAIT:
                    if (mul_done && !ph_reg && k_reg != 3'd0)
                        ph_reg <= 1'b1;
                cfr_pkg::ST_STORE:
                begin
                    ph_reg <= 1'b0;
                    if (k_reg < n_cur)
                        k_reg <= k_reg + 3'd1;
                    else
                    begin
                        k_reg   <= 3'd0;
                        sec_reg <= 1'b1;
                    end
                end
                cfr_pkg::ST_EMIT:
                    if (out_free && !last_ch)
                        ch_reg <= ch_reg + cfr_pkg::CH_W'(1);
                default: ;
            endcase
            if ((state_reg == cfr_pkg::ST_EMIT) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept && in_op == cfr_pkg::OP_PROCESS)
            sample_reg <= in_sample;
        case (state_reg)
            cfr_pkg::ST_LOAD:
            begin
                for (int i = 0; i < cfr_pkg::MAX_BAND_ORDER; i++)
                    bz_reg[i] <= band_row[i*DW +: DW];
                lz_reg[0] <= lp_row[DW-1:0];
                lz_reg[1] <= lp_row[2*DW-1:DW];
            end
            cfr_pkg::ST_STEP:
                acc_reg <= {{(cfr_pkg::ACC_W-DW){z_init[DW-1]}}, z_init};
            cfr_pkg::ST_WAIT:
                if (mul_done)
                    acc_reg <= ph_reg ? (acc_reg - res_ext) : (acc_reg + res_ext);
            cfr_pkg::ST_STORE:
            begin
                if (k_reg == 3'd0)
                begin
                    if (sec_reg)
                        yl_reg <= acc_sat;
                    else
                        yb_reg <= acc_sat;
                end
                else if (sec_reg)
                    lz_reg[k_reg[1]] <= acc_sat;   // step 1 -> z0, step 2 -> z1
                else
                    bz_reg[k_reg - 3'd1] <= acc_sat;
            end
            cfr_pkg::ST_EMIT:
                if (out_free)
                begin
                    och_reg   <= ch_reg;
                    oband_reg <= cfr_pkg::to_out(yb_reg);
                    orect_reg <= cfr_pkg::to_out(yl_reg);
                    olast_reg <= last_ch;
                end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, orect_reg, oband_reg, och_reg};
    assign m_tlast  = olast_reg;

    // checks
    `ASSERT_NEVER(a_mul_done_wait, clk, rst_n, mul_done && state_reg != cfr_pkg::ST_WAIT)
    `ASSERT_CLK(a_ch_range, clk, rst_n, (state_reg == cfr_pkg::ST_EMIT) |-> (ch_ext < nch_reg))
    `ASSERT_CLK(a_step_range, clk, rst_n, (state_reg == cfr_pkg::ST_STORE) |-> (k_reg <= n_cur))
endmodule
`default_nettype wire
